// File: hw/rtl/miq_pkg.sv
// Shared types and codes for the middle-insert queue.
// Depends on nothing; every other file of the block but miq_ram imports it.
`default_nettype none

package miq_pkg;

  localparam int VALUE_W = 64;

  // Request codes.
  localparam logic [1:0] ACT_PUSH_BACK = 2'd0;
  localparam logic [1:0] ACT_PUSH_MID  = 2'd1;
  localparam logic [1:0] ACT_POP       = 2'd2;

  // Result codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } miq_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] popped_value;
  } miq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } miq_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } miq_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/middle_insert_queue_core.sv
// Top level of the middle-insert queue: controller and datapath.
// Depends on miq_pkg, miq_ctrl, miq_datapath and miq_ram.
// After a transfer the request executes while busy is high for one cycle.
// The result strobe is registered from that execute cycle, so it rises in the
// cycle after it; the receiver cannot stall it. Reset (synchronous,
// active low) empties the queue; RAM contents are not cleared.
`default_nettype none

module middle_insert_queue_core
  import miq_pkg::*;
#(
  parameter int QUEUE_CAPACITY = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire miq_in_t in_req,
  output logic         out_valid,
  output miq_out_t     out_res
);

  // A request is a transfer when start is high while busy is low. In the
  // cycle of the transfer both half rings read their head entries; in the
  // following cycle the datapath writes at most one entry to each ring,
  // which covers the push itself and the one entry that keeps the front
  // half at ceil(n/2) entries. The result register loads at that edge.
  miq_cmd_t cmd;

  miq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the rings, their start and size registers and the
  // result register with its strobe.
  miq_datapath #(.QUEUE_CAPACITY(QUEUE_CAPACITY)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Every result strobe follows a busy cycle and never comes during one.
  a_strobe_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe during busy cycle");

endmodule

`default_nettype wire

// File: hw/rtl/miq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module miq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/miq_ctrl.sv
// Controller of the middle-insert queue: a two-state sequencer.
// Depends on miq_pkg.
`default_nettype none

module miq_ctrl
  import miq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output miq_cmd_t  cmd
);

  miq_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Execution lasts exactly one cycle and always follows a transfer.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("execute phase lasted more than one cycle");

  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted request was not executed");

endmodule

`default_nettype wire

// File: hw/rtl/miq_datapath.sv
// Datapath of the middle-insert queue: the two half rings, their pointers and the result register.
// Depends on miq_pkg and miq_ram.
`default_nettype none

module miq_datapath
  import miq_pkg::*;
#(
  parameter int QUEUE_CAPACITY = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire miq_cmd_t cmd,
  input  wire miq_in_t in_req,
  output logic         out_valid,
  output miq_out_t     out_res
);

  localparam int HALF = (QUEUE_CAPACITY + 1) / 2;
  localparam int PW   = HALF > 1 ? $clog2(HALF) : 1;
  localparam int SW   = $clog2(HALF + 1);
  localparam int FW   = $clog2(QUEUE_CAPACITY + 1);

  miq_in_t        req_r;
  logic [PW-1:0]  front_start_r, front_start_nxt;
  logic [PW-1:0]  back_start_r, back_start_nxt;
  logic [SW-1:0]  front_size_r, front_size_nxt;
  logic [SW-1:0]  back_size_r, back_size_nxt;
  logic           out_valid_r;
  miq_out_t       out_res_r, out_res_nxt;

  logic                 f_we, b_we;
  logic [PW-1:0]        f_waddr, b_waddr;
  logic [VALUE_W-1:0]   f_wdata, b_wdata;
  logic [VALUE_W-1:0]   f_rdata, b_rdata;
  logic [FW-1:0]        fill;
  logic                 fill_even, full, empty;
  logic [PW-1:0]        front_tail, back_tail;

  function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [SW-1:0] ofs);
    logic [SW:0] sum;
    sum = (SW+1)'(base) + (SW+1)'(ofs);
    if (sum >= (SW+1)'(HALF)) begin
      sum = sum - (SW+1)'(HALF);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(logic [PW-1:0] p);
    return (p == PW'(HALF - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(HALF - 1) : p - PW'(1);
  endfunction

  miq_ram #(.WIDTH(VALUE_W), .DEPTH(HALF)) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (cmd.load),
    .raddr (front_start_r),
    .rdata (f_rdata)
  );

  miq_ram #(.WIDTH(VALUE_W), .DEPTH(HALF)) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (cmd.load),
    .raddr (back_start_r),
    .rdata (b_rdata)
  );

  assign fill       = FW'(front_size_r) + FW'(back_size_r);
  assign fill_even  = !fill[0];
  assign full       = fill >= FW'(QUEUE_CAPACITY);
  assign empty      = fill == '0;
  assign front_tail = ring_add(front_start_r, front_size_r);
  assign back_tail  = ring_add(back_start_r, back_size_r);

  // The front half always holds ceil(n/2) entries, so on a push or pop that
  // starts from an even fill the back head moves to the front tail.
  always_comb begin
    f_we            = 1'b0;
    f_waddr         = front_tail;
    f_wdata         = req_r.value;
    b_we            = 1'b0;
    b_waddr         = back_tail;
    b_wdata         = req_r.value;
    front_start_nxt = front_start_r;
    back_start_nxt  = back_start_r;
    front_size_nxt  = front_size_r;
    back_size_nxt   = back_size_r;
    out_res_nxt     = '0;
    if (cmd.exec) begin
      case (req_r.action) inside
        ACT_PUSH_BACK, ACT_PUSH_MID: begin
          if (full) begin
            out_res_nxt.status = STAT_FULL;
          end else if (req_r.action == ACT_PUSH_BACK) begin
            if (fill_even) begin
              f_we           = 1'b1;
              front_size_nxt = front_size_r + SW'(1);
              if (back_size_r != '0) begin
                f_wdata        = b_rdata;
                b_we           = 1'b1;
                back_start_nxt = ring_inc(back_start_r);
              end
            end else begin
              b_we          = 1'b1;
              back_size_nxt = back_size_r + SW'(1);
            end
          end else begin
            if (fill_even) begin
              // The new entry would be shifted over at once, so it goes
              // straight to the front tail.
              f_we           = 1'b1;
              front_size_nxt = front_size_r + SW'(1);
            end else begin
              b_we           = 1'b1;
              b_waddr        = ring_dec(back_start_r);
              back_start_nxt = ring_dec(back_start_r);
              back_size_nxt  = back_size_r + SW'(1);
            end
          end
        end
        ACT_POP: begin
          if (empty) begin
            out_res_nxt.status = STAT_EMPTY;
          end else begin
            out_res_nxt.popped_value = f_rdata;
            front_start_nxt          = ring_inc(front_start_r);
            if (fill_even) begin
              f_we           = 1'b1;
              f_wdata        = b_rdata;
              back_start_nxt = ring_inc(back_start_r);
              back_size_nxt  = back_size_r - SW'(1);
            end else begin
              front_size_nxt = front_size_r - SW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.exec) begin
      out_res_r <= out_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_start_r <= '0;
      back_start_r  <= '0;
      front_size_r  <= '0;
      back_size_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      front_start_r <= front_start_nxt;
      back_start_r  <= back_start_nxt;
      front_size_r  <= front_size_nxt;
      back_size_r   <= back_size_nxt;
      out_valid_r   <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (front_size_r == back_size_r) ||
    ((SW+1)'(front_size_r) == (SW+1)'(back_size_r) + (SW+1)'(1)))
    else $error("halves out of balance");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed request produced no result");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for middle_insert_queue_core: directed and random requests,
// a queue model for the expected replies, and a strobe monitor.
// Depends on miq_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;
  import miq_pkg::*;

  // The bench runs the block at its default size. Each ring half holds
  // ceil(capacity/2) entries, so the fill phase below wraps both rings.
  localparam int CAP = 1024;
  localparam int HALF = (CAP + 1) / 2;
  // Action code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Longest run of cycles with neither a request transfer nor a reply before
  // the run is declared hung. The slowest legal stretch is a long random sender
  // gap plus the time the block takes to answer, far below this.
  localparam int STALL_LIMIT = 2000;

  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    miq_in_t     req;
    int unsigned gap_pct;         // chance per cycle that the sender idles
    bit          hold_for_drain;  // wait until every reply is back before sending
  } stim_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  miq_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  miq_out_t out_res;

  stim_item_t stim_q[$];
  miq_out_t   awaited_replies[$];
  int         n_planned = 0;
  int         n_sent = 0;
  int         n_got = 0;
  int         n_bad = 0;
  int         idle_run = 0;
  int         gen_fill = 0;   // fill level seen by the stimulus generator

  // Model state: two rings, the front one holding the first ceil(n/2) entries.
  logic signed [63:0] front_mem[HALF];
  logic signed [63:0] back_mem[HALF];
  int unsigned        f_head = 0;
  int unsigned        b_head = 0;
  int unsigned        f_cnt = 0;
  int unsigned        b_cnt = 0;

  middle_insert_queue_core #(
    .QUEUE_CAPACITY(CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned ring_wrap(int unsigned base, int unsigned off);
    return (base + off) % HALF;
  endfunction

  // Move the head of the back ring to the tail of the front ring, which keeps
  // the front ring at ceil(n/2) entries.
  function automatic void rebalance();
    if (b_cnt == 0 || f_cnt >= HALF) return;
    front_mem[ring_wrap(f_head, f_cnt)] = back_mem[b_head];
    f_cnt++;
    b_head = ring_wrap(b_head, 1);
    b_cnt--;
  endfunction

  // Applies one request to the model queue and returns the reply it owes.
  function automatic miq_out_t serve_request(miq_in_t req);
    miq_out_t    res;
    int unsigned fill;
    res.status = STAT_OK;
    res.popped_value = '0;
    fill = f_cnt + b_cnt;
    case (req.action)
      ACT_PUSH_BACK, ACT_PUSH_MID: begin
        if (fill >= CAP) begin
          res.status = STAT_FULL;
        end else begin
          if (req.action == ACT_PUSH_BACK) begin
            back_mem[ring_wrap(b_head, b_cnt)] = req.value;
          end else begin
            // Inserting at the middle is a push onto the head of the back ring.
            b_head = ring_wrap(b_head, HALF - 1);
            back_mem[b_head] = req.value;
          end
          b_cnt++;
          if (fill % 2 == 0) rebalance();
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_value = front_mem[f_head];
          f_head = ring_wrap(f_head, 1);
          f_cnt--;
          if (fill % 2 == 0) rebalance();
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly random 64-bit words, with the extremes and the all-ones and zero
  // patterns mixed in often enough to matter.
  function automatic logic signed [63:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -64'sd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(logic [1:0] act, logic signed [63:0] val, int unsigned gap,
                          bit hold);
    stim_item_t it;
    it.req.action = act;
    it.req.value = val;
    it.gap_pct = gap;
    it.hold_for_drain = hold;
    stim_q.push_back(it);
    n_planned++;
    // The generator tracks the fill so that phases can aim for full or empty.
    if ((act == ACT_PUSH_BACK || act == ACT_PUSH_MID) && gen_fill < CAP) gen_fill++;
    else if (act == ACT_POP && gen_fill > 0) gen_fill--;
  endtask

  // Pushes are split evenly between tail and middle; whatever is left after
  // the push and pop weights goes to the unused action code.
  task automatic add_random(int unsigned push_w, int unsigned pop_w, int unsigned gap);
    int unsigned r;
    logic [1:0]  act;
    r = $urandom_range(99);
    if (r < push_w) act = $urandom_range(1) ? ACT_PUSH_MID : ACT_PUSH_BACK;
    else if (r < push_w + pop_w) act = ACT_POP;
    else act = ACT_UNUSED;
    add_item(act, pick_value(), gap, 1'b0);
  endtask

  task automatic flag_error(string what);
    n_bad++;
    if (n_bad <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Driver. A request is transferred at a rising edge where start is high and
  // busy is low; the model is updated at that same edge from the request that
  // was on the bus. start stays high across the busy cycle, so with no gap the
  // block sees requests back to back.
  always @(posedge clk) begin : drive
    stim_item_t nxt;
    logic       took;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        awaited_replies.push_back(serve_request(in_req));
        n_sent <= n_sent + 1;
      end
      if (start && !took) begin
        // The block is still busy: keep the request on the bus.
      end else if (stim_q.size() == 0) begin
        start <= 1'b0;
      end else if (stim_q[0].hold_for_drain && (took || n_sent != n_got)) begin
        // Pause here until the block has answered every request sent so far.
        start <= 1'b0;
      end else if ($urandom_range(99) < stim_q[0].gap_pct) begin
        start <= 1'b0;
      end else begin
        nxt = stim_q.pop_front();
        in_req <= nxt.req;
        start <= 1'b1;
      end
    end
  end

  // Monitor. The reply strobe lasts one cycle and cannot be held off, so every
  // cycle with out_valid high is one transfer, checked against the oldest
  // reply the model owes.
  always @(posedge clk) begin : watch_replies
    miq_out_t want;
    if (rst_n && out_valid) begin
      n_got <= n_got + 1;
      if (awaited_replies.size() == 0) begin
        flag_error($sformatf("reply with none expected: status %0d value %0d",
                             out_res.status, out_res.popped_value));
      end else begin
        want = awaited_replies.pop_front();
        if (out_res.status !== want.status)
          flag_error($sformatf("status expected %0d got %0d", want.status,
                               out_res.status));
        if (out_res.popped_value !== want.popped_value)
          flag_error($sformatf("popped value expected %0d got %0d",
                               want.popped_value, out_res.popped_value));
      end
    end
  end

  // Watchdog: any cycle with a transfer in either direction restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    // Directed part: pop on empty, middle insertion on an empty and on a
    // one-entry queue (both act as tail pushes), the value extremes and
    // alternating bit patterns, the unused action, then a full drain that ends
    // with one more pop on empty.
    add_item(ACT_POP, VAL_MAX, 0, 1'b0);
    add_item(ACT_PUSH_MID, -64'sd5, 0, 1'b0);
    add_item(ACT_PUSH_MID, VAL_MAX, 0, 1'b0);
    add_item(ACT_PUSH_BACK, VAL_MIN, 0, 1'b0);
    add_item(ACT_PUSH_MID, '0, 0, 1'b0);
    add_item(ACT_PUSH_BACK, -64'sd1, 0, 1'b0);
    add_item(ACT_PUSH_MID, 64'shaaaa_aaaa_aaaa_aaaa, 0, 1'b0);
    add_item(ACT_PUSH_BACK, 64'sh5555_5555_5555_5555, 0, 1'b0);
    add_item(ACT_UNUSED, -64'sd1, 0, 1'b0);
    repeat (8) add_item(ACT_POP, pick_value(), 0, 1'b0);

    // Random part, in phases. First a balanced mix with no sender gaps, which
    // keeps the queue near empty so that pops on empty recur.
    repeat (150) add_random(48, 48, 0);
    // Fill to capacity with a mostly idle sender, which wraps the rings, then
    // linger at the top so that pushes of both kinds hit a full queue.
    while (gen_fill < CAP) add_random(96, 2, 83);
    repeat (15) add_random(70, 25, 83);
    // Wait for every reply, then drain to half fill with short random gaps.
    add_item(ACT_POP, pick_value(), 24, 1'b1);
    while (gen_fill > CAP / 2) add_random(3, 95, 24);
    // Close with a balanced mix around half fill and no sender gaps.
    repeat (40) add_random(48, 48, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every request sent, then every reply back, then a wait so that a stray
    // strobe can show up.
    while (n_sent < n_planned) @(posedge clk);
    while (n_got < n_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_replies.size() != 0)
      flag_error($sformatf("%0d replies never arrived", awaited_replies.size()));

    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/miq_pkg.sv
hw/rtl/miq_ram.sv
hw/rtl/miq_ctrl.sv
hw/rtl/miq_datapath.sv
hw/rtl/middle_insert_queue_core.sv
bench/tb.sv
